>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/bole_pkg.sv
// Types and constants for the bounded ordered list engine
package bole_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_REMOVE    = 3'd2;
    localparam logic [2:0] REQ_REM_LAST  = 3'd3;
    localparam logic [2:0] REQ_SEARCH    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] length;
    } rsp_t;

endpackage

>>> rtl/bounded_ordered_list_engine_core.sv
// Linked list engine: slot memories, free-slot map and a walk sequencer
// Full/empty/unknown requests skip the scan and the walk; insert scans for the lowest free
// slot (one free bit checked per cycle); insert back to a non-empty list also links the tail.
// Remove, search and remove last (beyond a single entry) walk one list entry per cycle.
// One request at a time; a finished response waits in the output register while the next
// request is taken. Reset: asynchronous active-low, empty list, all slots free.
module bounded_ordered_list_engine_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bole_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bole_pkg::rsp_t  rsp_data
);
    import bole_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LINK = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [1:0]         status_reg, status_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [31:0]        val_mem [CAPACITY];
    logic [IDX_W-1:0]   link_mem [CAPACITY];
    logic [31:0]        rd_val_reg;
    logic [IDX_W-1:0]   rd_link_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               val_we;
    logic               link_we;
    logic [IDX_W-1:0]   link_waddr;
    logic [IDX_W-1:0]   link_wdata;
    logic               last_step;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign last_step = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[i_reg] <= req_reg.value;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        rd_val_reg  <= val_mem[rd_addr];
        rd_link_reg <= link_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd_addr        = head_reg;
        val_we         = 1'b0;
        link_we        = 1'b0;
        link_waddr     = cur_reg;
        link_wdata     = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next    = req_data;
                    i_next      = '0;
                    cur_next    = head_reg;
                    prev_next   = head_reg;
                    status_next = ST_OK;
                    pos_next    = '0;
                    state_next  = S_DONE;
                    if (req_data.req_type == REQ_INS_FRONT || req_data.req_type == REQ_INS_BACK)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                            status_next = ST_FULL;
                        else
                            state_next = S_SCAN;
                    end
                    else if (req_data.req_type == REQ_REMOVE
                             || req_data.req_type == REQ_SEARCH)
                    begin
                        if (count_reg == '0)
                            status_next = ST_EMPTY;
                        else
                            state_next = S_WALK;
                    end
                    else if (req_data.req_type == REQ_REM_LAST)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (count_reg == CNT_W'(1))
                        begin
                            free_next[tail_reg] = 1'b1;
                            count_next          = '0;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (free_reg[i_reg])
                begin
                    val_we           = 1'b1;
                    link_we          = 1'b1;
                    link_waddr       = i_reg;
                    link_wdata       = (count_reg == '0 || req_reg.req_type == REQ_INS_BACK)
                                       ? i_reg : head_reg;
                    free_next[i_reg] = 1'b0;
                    count_next       = count_reg + CNT_W'(1);
                    cur_next         = i_reg;
                    state_next       = S_DONE;
                    if (count_reg == '0)
                    begin
                        head_next = i_reg;
                        tail_next = i_reg;
                    end
                    else if (req_reg.req_type == REQ_INS_FRONT)
                    begin
                        head_next = i_reg;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end

            S_LINK:
            begin
                // old tail now points at the new entry
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = cur_reg;
                tail_next  = cur_reg;
                state_next = S_DONE;
            end

            S_WALK:
            begin
                rd_addr = rd_link_reg;
                if (req_reg.req_type == REQ_REM_LAST)
                begin
                    if (CNT_W'(i_reg) + CNT_W'(2) == count_reg)
                    begin
                        // cur is the entry before the last
                        link_we             = 1'b1;
                        link_waddr          = cur_reg;
                        link_wdata          = cur_reg;
                        free_next[tail_reg] = 1'b1;
                        tail_next           = cur_reg;
                        count_next          = count_reg - CNT_W'(1);
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = rd_link_reg;
                        i_next    = i_reg + IDX_W'(1);
                    end
                end
                else if (rd_val_reg == req_reg.value)
                begin
                    state_next = S_DONE;
                    if (req_reg.req_type == REQ_SEARCH)
                    begin
                        pos_next = POS_W'(i_reg);
                    end
                    else
                    begin
                        if (i_reg == '0)
                        begin
                            head_next = rd_link_reg;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = rd_link_reg;
                            if (cur_reg == tail_reg)
                                tail_next = prev_reg;
                        end
                        free_next[cur_reg] = 1'b1;
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
                else if (last_step)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = rd_link_reg;
                    i_next    = i_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.status   = status_reg;
                    rsp_next.position = pos_reg;
                    rsp_next.length   = LEN_W'(count_reg);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        i_reg      <= i_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        rsp_reg    <= rsp_next;
    end

endmodule

>>> rtl/bole_checker.sv
// Port-level checks for the list engine, bound to bounded_ordered_list_engine_core
`include "assert_macros.svh"

module bole_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bole_pkg::rsp_t rsp_data
);
    import bole_pkg::*;

    // a stalled response holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
                 rsp_valid && $stable(rsp_data))
    // engine is busy the cycle after taking a request
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMP(a_full_len, clk, rst_n, rsp_valid && rsp_data.status == ST_FULL,
                rsp_data.length == LEN_W'(CAPACITY))
    `ASSERT_IMP(a_empty_len, clk, rst_n, rsp_valid && rsp_data.status == ST_EMPTY,
                rsp_data.length == '0)
    // only a successful search reports a nonzero position
    `ASSERT_IMP(a_pos_ok, clk, rst_n, rsp_valid && rsp_data.position != '0,
                rsp_data.status == ST_OK)

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
